// File: design/fpda_pkg.sv
// Shared types and constants for the fixed-point to decimal ASCII core.
// Depends on nothing; imported by every module of the core.
package fpda_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SIGN,
        S_INT,
        S_POINT,
        S_FRAC
    } state_t;

    localparam int INT_DIGITS = 5;
    localparam int INT_CNT_W  = 3;
    localparam int ACC_W      = 33;
    localparam int REM_W      = 29;

    // ceil(2^29 / 10000): scales the integer part into a 29-bit binary fraction.
    localparam logic [15:0] INT_RECIP = 16'd53688;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_POINT = 8'h2E;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;

    typedef struct packed {
        logic load;
        logic seed_int;
        logic seed_frac;
        logic step;
    } dp_ctrl_t;

    typedef struct packed {
        logic       neg;
        logic [3:0] digit;
    } dp_stat_t;

endpackage

// File: design/fixed_point_to_decimal_ascii_core.sv
// Top level of the signed 16.16 fixed-point to decimal ASCII formatter.
// Depends on fpda_pkg, fpda_dp and fpda_mul10.
//
// Channel   Direction  Beat marked by         Payload
// input     in         start && !busy         value
// result    out        strobe                 character, last
//
// After acceptance a value keeps busy high through a sign state, five integer digit
// steps, a point state and one step per fraction digit, with every digit step going
// through the single times-ten unit. A new value is accepted only while busy is low.
// Each character leaves through an output register after its step.
// Reset clears the sequencer and the output strobe. The receiver cannot stall.
module fixed_point_to_decimal_ascii_core
    import fpda_pkg::*;
#(
    parameter int FRACTION_DIGITS = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [31:0] value,
    output logic        strobe,
    output logic [7:0]  character,
    output logic        last
);

    localparam int FracCntW = $clog2(FRACTION_DIGITS + 1);

    state_t                state_reg;
    state_t                state_next;
    logic [INT_CNT_W-1:0]  int_cnt_reg;
    logic [INT_CNT_W-1:0]  int_cnt_next;
    logic [FracCntW-1:0]   frac_cnt_reg;
    logic [FracCntW-1:0]   frac_cnt_next;
    logic                  seen_reg;
    logic                  seen_next;
    logic                  strobe_reg;
    logic                  strobe_next;
    logic [7:0]            char_reg;
    logic [7:0]            char_next;
    logic                  last_reg;
    logic                  last_next;
    dp_ctrl_t              ctrl;
    dp_stat_t              stat;
    logic [7:0]            digit_char;

    fpda_dp u_dp (
        .clk   (clk),
        .value (value),
        .ctrl  (ctrl),
        .stat  (stat)
    );

    assign digit_char = ASCII_ZERO + {4'd0, stat.digit};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            int_cnt_reg  <= '0;
            frac_cnt_reg <= '0;
            seen_reg     <= 1'b0;
            strobe_reg   <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            int_cnt_reg  <= int_cnt_next;
            frac_cnt_reg <= frac_cnt_next;
            seen_reg     <= seen_next;
            strobe_reg   <= strobe_next;
            last_reg     <= last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    always_comb
    begin
        state_next    = state_reg;
        int_cnt_next  = int_cnt_reg;
        frac_cnt_next = frac_cnt_reg;
        seen_next     = seen_reg;
        strobe_next   = 1'b0;
        char_next     = char_reg;
        last_next     = 1'b0;
        ctrl          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctrl.load  = 1'b1;
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                ctrl.seed_int = 1'b1;
                strobe_next   = stat.neg;
                char_next     = ASCII_MINUS;
                int_cnt_next  = '0;
                seen_next     = 1'b0;
                state_next    = S_INT;
            end
            S_INT:
            begin
                ctrl.step = 1'b1;
                if ((stat.digit != 4'd0) || seen_reg
                    || (int_cnt_reg == INT_CNT_W'(INT_DIGITS - 1)))
                begin
                    strobe_next = 1'b1;
                    char_next   = digit_char;
                    seen_next   = 1'b1;
                end
                int_cnt_next = int_cnt_reg + 1'b1;
                if (int_cnt_reg == INT_CNT_W'(INT_DIGITS - 1))
                begin
                    state_next = S_POINT;
                end
            end
            S_POINT:
            begin
                ctrl.seed_frac = 1'b1;
                strobe_next    = 1'b1;
                char_next      = ASCII_POINT;
                frac_cnt_next  = '0;
                state_next     = S_FRAC;
            end
            S_FRAC:
            begin
                ctrl.step     = 1'b1;
                strobe_next   = 1'b1;
                char_next     = digit_char;
                frac_cnt_next = frac_cnt_reg + 1'b1;
                if (frac_cnt_reg == FracCntW'(FRACTION_DIGITS - 1))
                begin
                    last_next  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy      = (state_reg != S_IDLE);
    assign strobe    = strobe_reg;
    assign character = char_reg;
    assign last      = last_reg;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("Accepted value did not raise busy.");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && last |=> !strobe)
        else $error("Character followed the final character directly.");

    a_mid_text_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last |-> busy)
        else $error("Text left unfinished while idle.");

    a_point_char: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_POINT |=> strobe && (character == ASCII_POINT))
        else $error("Decimal point missing after integer digits.");

endmodule

// File: design/fpda_mul10.sv
// Shared times-ten unit: scales a 29-bit fraction by ten.
// Depends on fpda_pkg; used by fpda_dp for every digit.
module fpda_mul10
    import fpda_pkg::*;
(
    input  logic [REM_W-1:0] operand,
    output logic [ACC_W-1:0] product
);

    logic [ACC_W-1:0] wide;

    assign wide    = {{(ACC_W-REM_W){1'b0}}, operand};
    assign product = (wide << 3) + (wide << 1);

endmodule

// File: design/fpda_dp.sv
// Datapath: magnitude register, digit accumulator and integer scaling.
// Depends on fpda_pkg and fpda_mul10.
module fpda_dp
    import fpda_pkg::*;
(
    input  logic        clk,
    input  logic [31:0] value,
    input  dp_ctrl_t    ctrl,
    output dp_stat_t    stat
);

    logic [31:0]      mag_reg;
    logic [31:0]      mag_next;
    logic             neg_reg;
    logic [ACC_W-1:0] acc_reg;
    logic [ACC_W-1:0] acc_next;
    logic [REM_W-1:0] unit_in;
    logic [ACC_W-1:0] unit_out;
    logic [31:0]      scaled;

    fpda_mul10 u_mul10 (
        .operand (unit_in),
        .product (unit_out)
    );

    assign scaled = mag_reg[31:16] * INT_RECIP;

    always_comb
    begin
        if (ctrl.seed_frac)
        begin
            unit_in = {mag_reg[15:1], {(REM_W-15){1'b0}}};
        end
        else
        begin
            unit_in = acc_reg[REM_W-1:0];
        end
    end

    always_comb
    begin
        mag_next = value[31] ? (32'd0 - value) : value;
        acc_next = acc_reg;
        if (ctrl.seed_int)
        begin
            acc_next = {{(ACC_W-32){1'b0}}, scaled};
        end
        else if (ctrl.seed_frac || ctrl.step)
        begin
            acc_next = unit_out;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            mag_reg <= mag_next;
            neg_reg <= value[31];
        end
        acc_reg <= acc_next;
    end

    assign stat.neg   = neg_reg;
    assign stat.digit = acc_reg[ACC_W-1:REM_W];

endmodule
